>>> sv/swsm_pkg.sv
// shared types, register indexes and byte helpers for the substring word start matcher
package swsm_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] RegPatternLow  = 2'd0;
  localparam logic [1:0] RegPatternHigh = 2'd1;
  localparam logic [1:0] RegPatternLen  = 2'd2;
  localparam logic [1:0] RegMatchMode   = 2'd3;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned LenW      = 5;
  localparam int unsigned PatBytes  = 16;

  // per-cycle control shared by every window cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  // ascii letter and digit test
  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  // upper case letters to lower case, everything else untouched
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if ((c >= 8'h41) && (c <= 8'h5a)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage

>>> sv/swsm_if.sv
// valid/ready channel interfaces for text words and match results
interface swsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       char_valid;
  logic       last_char;

  modport source (output valid, output text_char, output char_valid, output last_char,
                  input ready);
  modport sink (input valid, input text_char, input char_valid, input last_char,
                output ready);
endinterface

interface swsm_out_if;
  logic valid;
  logic ready;
  logic match_found;

  modport source (output valid, output match_found, input ready);
  modport sink (input valid, input match_found, output ready);
endinterface

>>> sv/substring_word_start_matcher_top.sv
// top level of the streaming substring matcher with optional word start rule
//
//   channel   direction  word                              handshake
//   text_i    in         text_char, char_valid, last_char  valid/ready
//   result_o  out        match_found                       valid/ready
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i   write enable only
//
// one text word per cycle; the window of MAX_PATTERN cells shifts and compares in the
// same cycle, and the result of a last word is registered in the result buffer.
// reset clears window, flags, counters and registers at once.
// text_i stalls only when both result buffer entries are waiting to be taken.
module substring_word_start_matcher_top #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [swsm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  swsm_in_if.sink                        text_i,
  swsm_out_if.source                     result_o
);

  localparam int unsigned CntW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = swsm_pkg::LenW;

  // configuration registers
  logic [63:0]     pat_lo_q, pat_hi_q;
  logic [LenW-1:0] len_q;
  logic            mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swsm_pkg::RegPatternLow:  pat_lo_q <= cfg_wdata_i;
        swsm_pkg::RegPatternHigh: pat_hi_q <= cfg_wdata_i;
        swsm_pkg::RegPatternLen:  len_q    <= cfg_wdata_i[LenW-1:0];
        swsm_pkg::RegMatchMode:   mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stream state
  logic            prev_na_q, prev_na_d;
  logic [CntW-1:0] bytes_q, bytes_d, bytes_new;
  logic            found_q, found_d;

  logic            accept, take, last, full, hit, result;
  logic [LenW-1:0] eff_len;
  logic            len_nz, all_eq, start_sel;
  logic            new_start;
  logic [IdxW-1:0] sel_idx;
  logic [7:0]      pat_byte [swsm_pkg::PatBytes];

  logic [7:0]             cell_byte_in  [MAX_PATTERN];
  logic [7:0]             cell_byte_out [MAX_PATTERN];
  logic [7:0]             cell_pat      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_start_in;
  logic [MAX_PATTERN-1:0] cell_start_out;
  logic [MAX_PATTERN-1:0] cell_eq;
  logic [MAX_PATTERN-1:0] cell_used;
  swsm_pkg::cell_ctrl_t   ctrl;

  assign text_i.ready = !full;
  assign accept       = text_i.valid && text_i.ready;
  assign take         = accept && text_i.char_valid;
  assign last         = accept && text_i.last_char;

  // effective pattern length, capped at the window size
  assign eff_len = (len_q > LenW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN) : len_q;
  assign len_nz  = eff_len != '0;

  // pattern bytes, byte 0 lowest
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pat_byte[b]     = pat_lo_q[8*b +: 8];
      pat_byte[b + 8] = pat_hi_q[8*b +: 8];
    end
  end

  // word start flag of the incoming byte
  assign new_start = swsm_pkg::is_alnum(text_i.text_char) && prev_na_q;

  assign ctrl.shift = take && !last;
  assign ctrl.clear = last;
  assign ctrl.fold  = mode_q;

  // chain of window cells, cell 0 newest
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LenW-1:0] pidx;

    if (k == 0) begin : g_head
      assign cell_byte_in[k]  = text_i.text_char;
      assign cell_start_in[k] = new_start;
    end else begin : g_link
      assign cell_byte_in[k]  = cell_byte_out[k-1];
      assign cell_start_in[k] = cell_start_out[k-1];
    end

    // cell k holds the byte that lines up with pattern byte eff_len-1-k
    assign pidx         = eff_len - LenW'(1) - LenW'(k);
    assign cell_pat[k]  = pat_byte[pidx[3:0]];
    assign cell_used[k] = LenW'(k) < eff_len;

    swsm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .byte_i  (cell_byte_in[k]),
      .start_i (cell_start_in[k]),
      .pat_i   (cell_pat[k]),
      .byte_o  (cell_byte_out[k]),
      .start_o (cell_start_out[k]),
      .eq_o    (cell_eq[k])
    );
  end

  // window compare on the shifted-in contents
  assign all_eq    = &(cell_eq | ~cell_used);
  assign sel_idx   = IdxW'(eff_len - LenW'(1));
  assign start_sel = cell_start_in[sel_idx];
  assign bytes_new = (bytes_q < CntW'(MAX_PATTERN)) ? bytes_q + CntW'(1) : bytes_q;
  assign hit       = take && len_nz && (LenW'(bytes_new) >= eff_len) && all_eq &&
                     (!mode_q || start_sel);
  assign result    = found_q || hit || (!mode_q && !len_nz);

  // stream state update
  always_comb begin
    prev_na_d = prev_na_q;
    bytes_d   = bytes_q;
    found_d   = found_q;
    if (last) begin
      prev_na_d = 1'b1;
      bytes_d   = '0;
      found_d   = 1'b0;
    end else if (take) begin
      prev_na_d = !swsm_pkg::is_alnum(text_i.text_char);
      bytes_d   = bytes_new;
      found_d   = found_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_na_q <= 1'b1;
      bytes_q   <= '0;
      found_q   <= 1'b0;
    end else begin
      prev_na_q <= prev_na_d;
      bytes_q   <= bytes_d;
      found_q   <= found_d;
    end
  end

  swsm_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (last),
    .data_i (result),
    .full_o (full),
    .out_o  (result_o)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |-> !full)
    else $error("result pushed into full buffer");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> (bytes_q == '0) && !found_q && prev_na_q)
    else $error("stream state not cleared after last word");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= CntW'(MAX_PATTERN))
    else $error("byte count above window size");

  a_empty_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last && !mode_q && (len_q == '0)) |-> result)
    else $error("empty pattern in exact mode must match");

endmodule

>>> sv/swsm_cell.sv
// one window cell: holds a text byte and its word start flag, compares the incoming byte
module swsm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swsm_pkg::cell_ctrl_t  ctrl_i,
  input  logic [7:0]            byte_i,
  input  logic                  start_i,
  input  logic [7:0]            pat_i,
  output logic [7:0]            byte_o,
  output logic                  start_o,
  output logic                  eq_o
);

  logic [7:0] byte_q, byte_d;
  logic       start_q, start_d;

  // compare the byte that moves in against this cell's pattern byte
  always_comb begin
    if (ctrl_i.fold) begin
      eq_o = swsm_pkg::fold_case(byte_i) == swsm_pkg::fold_case(pat_i);
    end else begin
      eq_o = byte_i == pat_i;
    end
  end

  // shift or clear
  always_comb begin
    byte_d  = byte_q;
    start_d = start_q;
    if (ctrl_i.clear) begin
      byte_d  = 8'h00;
      start_d = 1'b0;
    end else if (ctrl_i.shift) begin
      byte_d  = byte_i;
      start_d = start_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= 8'h00;
      start_q <= 1'b0;
    end else begin
      byte_q  <= byte_d;
      start_q <= start_d;
    end
  end

  assign byte_o  = byte_q;
  assign start_o = start_q;

endmodule

>>> sv/swsm_outbuf.sv
// two-entry result buffer between the matcher and the result channel
module swsm_outbuf (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  logic  data_i,
  output logic  full_o,
  swsm_out_if.source out_o
);

  logic [1:0] data_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = count_q != 2'd0;
  assign out_o.match_found = data_q[rd_ptr_q];
  assign full_o      = count_q == 2'd2;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for the substring word start matcher: directed table, then random texts
module tb_top;

  localparam int unsigned WinDepth    = 16;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned WordTarget  = 400;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned IdlePct     = 24;

  // how a directed text is judged: by the predictor or by a typed answer
  typedef enum logic [1:0] {
    AnsModel,
    AnsNo,
    AnsYes
  } answer_e;

  // one directed text, bytes in txt with the first byte lowest
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic        mode;
    logic [31:0] txt;
    int          n;
    int          hole;
    logic        open_end;
    answer_e     ans;
  } text_case_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          cfg_we;
  logic [swsm_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [swsm_pkg::CfgDataW-1:0] cfg_wdata;

  swsm_in_if  text_if ();
  swsm_out_if res_if ();

  substring_word_start_matcher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .text_i      (text_if),
    .result_o    (res_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and its copy of the registers
  logic [127:0] pred_pat;
  logic [4:0]   pred_len;
  logic         pred_mode;
  logic [7:0]   win [WinDepth];
  logic         word_start [WinDepth];
  logic         after_sep;
  int unsigned  fill;
  logic         seen_hit;

  // stimulus view of the current registers
  logic [127:0] cur_pat;
  logic [4:0]   cur_len;
  logic         cur_mode;

  logic         verdict_q [$];
  logic [7:0]   text_buf [$];
  answer_e      row_answer;
  logic         steady;
  int unsigned  hold_req;
  int unsigned  hold_seen;
  int unsigned  hold_left;
  int unsigned  cycle_count;
  int unsigned  mismatches;
  int unsigned  words_sent;
  int unsigned  verdicts_checked;
  int unsigned  verdicts_true;
  int unsigned  config_writes;

  text_case_t   dir_rows [9];

  function automatic logic is_word_byte(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'h20 : c;
  endfunction

  // lengths above the window are clipped to it
  function automatic int unsigned used_len(input logic [4:0] l);
    return (l > WinDepth) ? WinDepth : int'(l);
  endfunction

  function automatic void clear_text();
    int unsigned i;
    for (i = 0; i < WinDepth; i++) begin
      win[i] = 8'h00;
      word_start[i] = 1'b0;
    end
    after_sep = 1'b1;
    fill = 0;
    seen_hit = 1'b0;
  endfunction

  // shift one byte into the window and compare under the registers in force
  function automatic void scan_byte(input logic [7:0] c);
    int unsigned n;
    int unsigned i;
    logic hit;
    n = used_len(pred_len);
    for (i = WinDepth - 1; i > 0; i--) begin
      win[i] = win[i-1];
      word_start[i] = word_start[i-1];
    end
    win[0] = c;
    word_start[0] = is_word_byte(c) && after_sep;
    after_sep = !is_word_byte(c);
    if (fill < WinDepth) fill++;
    if ((n == 0) || (fill < n)) return;
    hit = pred_mode ? word_start[n-1] : 1'b1;
    for (i = 0; i < n; i++) begin
      if (pred_mode) begin
        if (lower(win[n-1-i]) != lower(pred_pat[8*i +: 8])) hit = 1'b0;
      end else begin
        if (win[n-1-i] != pred_pat[8*i +: 8]) hit = 1'b0;
      end
    end
    if (hit) seen_hit = 1'b1;
  endfunction

  // answer for a closed text; empty pattern matches only in exact mode
  function automatic logic text_verdict();
    logic v;
    v = seen_hit || (!pred_mode && (used_len(pred_len) == 0));
    clear_text();
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t: %s", $time, what);
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("run stopped after %0d cycles with %0d answers pending", cycle_count,
               verdict_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // check result words, predict from accepted text words, track register writes
  always @(posedge clk_i) begin
    logic want;
    logic got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.match_found;
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("result %b with no text pending", got));
        end else begin
          want = verdict_q.pop_front();
          verdicts_checked++;
          if (want) verdicts_true++;
          if (got !== want)
            flag_mismatch($sformatf("match_found %b, expected %b", got, want));
        end
      end
      if (text_if.valid && text_if.ready) begin
        if (text_if.char_valid) scan_byte(text_if.text_char);
        if (text_if.last_char) begin
          want = text_verdict();
          case (row_answer)
            AnsNo:   verdict_q.push_back(1'b0);
            AnsYes:  verdict_q.push_back(1'b1);
            default: verdict_q.push_back(want);
          endcase
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          swsm_pkg::RegPatternLow:  pred_pat[63:0] = cfg_wdata;
          swsm_pkg::RegPatternHigh: pred_pat[127:64] = cfg_wdata;
          swsm_pkg::RegPatternLen:  pred_len = cfg_wdata[4:0];
          swsm_pkg::RegMatchMode:   pred_mode = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // result side: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // offer one text word, with random gaps ahead of it
  task automatic send_word(input logic [7:0] ch, input logic has_byte, input logic ends);
    while (!steady && ($urandom_range(99) < IdlePct)) begin
      text_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    text_if.valid <= 1'b1;
    text_if.text_char <= ch;
    text_if.char_valid <= has_byte;
    text_if.last_char <= ends;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (has_byte || ends) words_sent++;
  endtask

  // wait for every pending answer, then for the block to settle
  task automatic drain();
    text_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [127:0] pat, input logic [4:0] len, input logic mode);
    cur_pat = pat;
    cur_len = len;
    cur_mode = mode;
    cfg_we <= 1'b1;
    cfg_idx <= swsm_pkg::RegPatternLow;
    cfg_wdata <= pat[63:0];
    @(negedge clk_i);
    cfg_idx <= swsm_pkg::RegPatternHigh;
    cfg_wdata <= pat[127:64];
    @(negedge clk_i);
    cfg_idx <= swsm_pkg::RegPatternLen;
    cfg_wdata <= 64'(len);
    @(negedge clk_i);
    cfg_idx <= swsm_pkg::RegMatchMode;
    cfg_wdata <= 64'(mode);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    config_writes += 4;
  endtask

  // letters, digits and separators, so that matches are common
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(5))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h41;
      3:       return 8'h42;
      4:       return 8'h30;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 3) return 8'($urandom_range(255));
    return pick_alpha();
  endfunction

  // random text; most of them carry the pattern, case flipped now and then
  function automatic void make_text();
    int unsigned k;
    int unsigned n;
    logic [7:0] b;
    text_buf = {};
    if ($urandom_range(9) < 4) begin
      n = $urandom_range(12);
      for (k = 0; k < n; k++) text_buf.push_back(pick_byte());
    end else begin
      n = $urandom_range(6);
      for (k = 0; k < n; k++) text_buf.push_back(pick_byte());
      if ($urandom_range(1)) text_buf.push_back($urandom_range(1) ? 8'h20 : 8'h2d);
      n = used_len(cur_len);
      for (k = 0; k < n; k++) begin
        b = cur_pat[8*k +: 8];
        if (is_word_byte(b) && (b >= 8'h41) &&
            (cur_mode ? ($urandom_range(1) == 1) : ($urandom_range(7) == 0)))
          b = b ^ 8'h20;
        text_buf.push_back(b);
      end
      n = $urandom_range(6);
      for (k = 0; k < n; k++) text_buf.push_back(pick_byte());
    end
  endfunction

  // send text_buf, with byteless words sprinkled in and sometimes a bare last word
  task automatic send_text(input logic open_end);
    int unsigned k;
    if (text_buf.size() == 0) begin
      send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      for (k = 0; k < text_buf.size(); k++) begin
        if ($urandom_range(99) < 4) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        send_word(text_buf[k], 1'b1, !open_end && (k == text_buf.size() - 1));
      end
      if (open_end) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    text_case_t  row;
    int          k;
    int unsigned r;
    int unsigned phase;
    int unsigned texts;
    logic [4:0]  len;
    logic        mode;
    logic [127:0] pat;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    text_if.valid = 1'b0;
    text_if.text_char = 8'h00;
    text_if.char_valid = 1'b0;
    text_if.last_char = 1'b0;
    res_if.ready = 1'b0;
    steady = 1'b0;
    row_answer = AnsModel;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    cycle_count = 0;
    mismatches = 0;
    words_sent = 0;
    verdicts_checked = 0;
    verdicts_true = 0;
    config_writes = 0;
    pred_pat = '0;
    pred_len = '0;
    pred_mode = 1'b0;
    cur_pat = '0;
    cur_len = '0;
    cur_mode = 1'b0;
    clear_text();

    // pattern "ab" is 16'h6261, texts read from the low byte up
    dir_rows = '{
      // empty pattern and empty text, exact mode
      '{64'h0, 64'h0, 5'd0, 1'b0, 32'h0, 0, -1, 1'b0, AnsYes},
      // empty pattern, word start mode
      '{64'h61, 64'h0, 5'd0, 1'b1, 32'h61, 1, -1, 1'b0, AnsNo},
      // empty text, word start mode
      '{64'h61, 64'h0, 5'd1, 1'b1, 32'h0, 0, -1, 1'b0, AnsNo},
      // empty text against a real pattern, exact mode
      '{64'h6261, 64'h0, 5'd2, 1'b0, 32'h0, 0, -1, 1'b0, AnsNo},
      // "xab" exact
      '{64'h6261, 64'h0, 5'd2, 1'b0, 32'h626178, 3, -1, 1'b0, AnsYes},
      // "aB" exact, case differs
      '{64'h6261, 64'h0, 5'd2, 1'b0, 32'h4261, 2, -1, 1'b0, AnsNo},
      // "-AB" folded at a word start
      '{64'h6261, 64'h0, 5'd2, 1'b1, 32'h42412d, 3, -1, 1'b0, AnsYes},
      // "xab" folded, but inside a word
      '{64'h6261, 64'h0, 5'd2, 1'b1, 32'h626178, 3, -1, 1'b0, AnsNo},
      // zero byte pattern, byteless word inside, bare last word
      '{64'h0, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b0, 32'h00ff, 2, 1, 1'b1, AnsYes}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed texts
    for (r = 0; r < $size(dir_rows); r++) begin
      row = dir_rows[r];
      drain();
      set_config({row.hi, row.lo}, row.len, row.mode);
      row_answer = row.ans;
      if (row.n == 0) begin
        send_word(8'h00, 1'b0, 1'b1);
      end else begin
        for (k = 0; k < row.n; k++) begin
          if (k == row.hole) send_word(8'h5a, 1'b0, 1'b0);
          send_word(row.txt[8*k +: 8], 1'b1, !row.open_end && (k == row.n - 1));
        end
        if (row.open_end) send_word(8'hff, 1'b0, 1'b1);
      end
    end
    drain();
    row_answer = AnsModel;

    // registers change in the middle of a text
    set_config(128'h7a, 5'd1, 1'b0);
    send_word(8'h7a, 1'b1, 1'b0);
    send_word(8'h51, 1'b1, 1'b0);
    drain();
    set_config(128'h0, 5'd0, 1'b1);
    send_word(8'h78, 1'b1, 1'b1);

    // random phases, each under its own register setting
    phase = 0;
    while ((words_sent < WordTarget) || (phase < 10)) begin
      drain();
      if ((phase == 6) || (phase == 7)) begin
        @(posedge clk_i);
        steady = (phase == 6);
        @(negedge clk_i);
      end
      case (phase)
        0, 1: len = 5'd0;
        2:    len = 5'd16;
        3:    len = 5'd31;
        default: begin
          case ($urandom_range(9))
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 6));
          endcase
        end
      endcase
      mode = (phase < 4) ? phase[0] : 1'($urandom_range(1));
      if (phase == 0) begin
        pat = '0;
      end else if ((phase == 2) || ($urandom_range(4) == 0)) begin
        pat = (phase == 2) ? '1 : {$urandom, $urandom, $urandom, $urandom};
      end else begin
        for (k = 0; k < WinDepth; k++) pat[8*k +: 8] = pick_alpha();
      end
      set_config(pat, len, mode);
      if (phase == 8) begin
        // results held back until the result buffer fills and text words stall
        @(posedge clk_i);
        hold_req++;
        @(negedge clk_i);
        for (k = 0; k < 12; k++) send_word(8'($urandom_range(255)), 1'b1, 1'b1);
      end
      texts = $urandom_range(2, 6);
      repeat (texts) begin
        make_text();
        send_text((text_buf.size() != 0) && ($urandom_range(9) == 0));
      end
      phase++;
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("covered %0d text words over %0d random phases, %0d register writes",
             words_sent, phase, config_writes);
    $display("%0d texts judged, %0d with the pattern found", verdicts_checked, verdicts_true);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
